// ===== src/dbx_pkg.sv =====
// Shared types, codes and CRC functions for the disk block extractor.
package dbx_pkg;

   localparam int unsigned WORD_W  = 16;
   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned COUNT_W = 17;
   localparam int unsigned KIND_W  = 2;
   localparam int unsigned INDEX_W = 3;
   localparam int unsigned SLOTS   = 4;

   localparam logic [KIND_W-1:0] KIND_DATA = 2'd0;
   localparam logic [KIND_W-1:0] KIND_CRC  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_END  = 2'd2;

   localparam logic [INDEX_W-1:0] REG_QUICK_DISK = 3'd0;
   localparam logic [INDEX_W-1:0] REG_GAP        = 3'd1;
   localparam logic [INDEX_W-1:0] REG_MARK       = 3'd2;
   localparam logic [INDEX_W-1:0] REG_CRC_FIRST  = 3'd3;
   localparam logic [INDEX_W-1:0] REG_CRC_SECOND = 3'd4;

   localparam logic [WORD_W-1:0] GAP_RESET        = 16'd256;
   localparam logic [WORD_W-1:0] MARK_RESET       = 16'd384;
   localparam logic [WORD_W-1:0] CRC_FIRST_RESET  = 16'd333;
   localparam logic [WORD_W-1:0] CRC_SECOND_RESET = 16'd339;

   localparam logic [15:0] CRC_POLY = 16'h8408;
   localparam logic [15:0] CRC_INIT = 16'h8000;

   localparam logic [COUNT_W-1:0] LEN_TYPE1 = 17'd56;
   localparam logic [COUNT_W-1:0] LEN_TYPE2 = 17'd2;
   localparam logic [COUNT_W-1:0] LEN_TYPE3 = 17'd16;

   localparam logic [2:0] TYPE_HEADER = 3'd3;
   localparam logic [4:0] IDX_LEN_LO  = 5'd13;
   localparam logic [4:0] IDX_LEN_HI  = 5'd14;
   localparam logic [4:0] IDX_MAX     = 5'd31;

   localparam int unsigned SLOT_DATA   = 0;
   localparam int unsigned SLOT_CRC_LO = 1;
   localparam int unsigned SLOT_CRC_HI = 2;
   localparam int unsigned SLOT_END    = 3;

   typedef enum logic [2:0] {
      PH_EXPECT  = 3'b001,
      PH_BLOCK   = 3'b010,
      PH_STOPPED = 3'b100
   } phase_type;

   typedef struct packed {
      logic              quick_disk_mode;
      logic [WORD_W-1:0] gap_code;
      logic [WORD_W-1:0] mark_code;
      logic [WORD_W-1:0] crc_first_code;
      logic [WORD_W-1:0] crc_second_code;
   } cfg_type;

   typedef struct packed {
      logic [SLOTS-1:0]   mask;
      logic [BYTE_W-1:0]  data_byte;
      logic [15:0]        crc_raw;
      logic [COUNT_W-1:0] cnt_data;
      logic [COUNT_W-1:0] cnt_crc_lo;
      logic [COUNT_W-1:0] cnt_crc_hi;
   } bundle_type;

   function automatic logic [15:0] crc_byte(input logic [15:0] sum_in,
                                            input logic [7:0] data);
      logic [15:0] sum;
      logic        carry;
      sum = sum_in;
      for (int k = 0; k < 8; k++) begin
         carry = sum[0];
         sum = {data[k], sum[15:1]};
         if (carry) begin
            sum = sum ^ CRC_POLY;
         end
      end
      return sum;
   endfunction

   function automatic logic [15:0] crc_finish(input logic [15:0] sum_in);
      return crc_byte(crc_byte(sum_in, 8'h00), 8'h00);
   endfunction

endpackage

// ===== src/dbx_req_if.sv =====
// Input channel: one image word per item.
interface dbx_req_if;
   import dbx_pkg::*;
   logic              valid;
   logic              ready;
   logic [WORD_W-1:0] image_word;
   logic              side_end;
   modport source (output valid, output image_word, output side_end, input ready);
   modport sink   (input valid, input image_word, input side_end, output ready);
endinterface

// ===== src/dbx_rsp_if.sv =====
// Result channel: one extracted byte or end record per item.
interface dbx_rsp_if;
   import dbx_pkg::*;
   logic               valid;
   logic               ready;
   logic [BYTE_W-1:0]  out_byte;
   logic [KIND_W-1:0]  byte_kind;
   logic [COUNT_W-1:0] bytes_emitted;
   logic               run_last;
   modport source (output valid, output out_byte, output byte_kind,
                   output bytes_emitted, output run_last, input ready);
   modport sink   (input valid, input out_byte, input byte_kind,
                   input bytes_emitted, input run_last, output ready);
endinterface

// ===== src/dbx_csr_if.sv =====
// Configuration write channel.
interface dbx_csr_if;
   import dbx_pkg::*;
   logic               valid;
   logic               ready;
   logic [INDEX_W-1:0] index;
   logic [WORD_W-1:0]  data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== src/dbx_parse.sv =====
// Block parser: holds the side state and builds the result bundle of each word.
module dbx_parse
   import dbx_pkg::*;
#(
   parameter logic [COUNT_W-1:0] SIDE_LIMIT = 17'd65536
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [WORD_W-1:0] image_word,
   input  logic              side_end,
   input  cfg_type           cfg,
   output bundle_type        bundle,
   output logic              bundle_load
);

   phase_type          phase_ff, phase_in;
   logic [COUNT_W-1:0] left_ff, left_in;
   logic [4:0]         index_ff, index_in;
   logic [2:0]         btype_ff, btype_in;
   logic [15:0]        flen_ff, flen_in;
   logic [15:0]        crc_ff, crc_in;
   logic [COUNT_W-1:0] count_ff, count_in;

   logic               is_type, starts, skip, in_block, done;
   logic [COUNT_W-1:0] left_eff, left_dec, c1, c2, c3;
   logic [4:0]         index_eff;
   logic [2:0]         btype_eff;
   logic [15:0]        crc_eff, crc_new;
   logic [7:0]         data;
   logic [SLOTS-1:0]   mask;

   always_comb begin
      data     = image_word[7:0];
      is_type  = (image_word >= 16'd1) && (image_word <= 16'd4);
      starts   = (phase_ff == PH_EXPECT) && is_type;
      skip     = (image_word == cfg.gap_code) || (image_word == cfg.mark_code) ||
                 (image_word == cfg.crc_first_code) ||
                 (image_word == cfg.crc_second_code);
      in_block = (phase_ff == PH_BLOCK) || starts;

      left_eff  = left_ff;
      btype_eff = btype_ff;
      index_eff = index_ff;
      crc_eff   = crc_ff;
      if (starts) begin
         unique case (image_word[2:0])
            3'd1:    left_eff = LEN_TYPE1;
            3'd2:    left_eff = LEN_TYPE2;
            3'd3:    left_eff = LEN_TYPE3;
            default: left_eff = {1'b0, flen_ff} + 17'd1;
         endcase
         btype_eff = image_word[2:0];
         index_eff = '0;
         crc_eff   = CRC_INIT;
      end

      crc_new  = crc_byte(crc_eff, data);
      left_dec = (left_eff != '0) ? left_eff - 17'd1 : '0;
      done     = in_block && (left_dec == '0);

      mask[SLOT_DATA]   = in_block && (count_ff < SIDE_LIMIT);
      c1                = count_ff + {16'd0, mask[SLOT_DATA]};
      mask[SLOT_CRC_LO] = done && cfg.quick_disk_mode && (c1 < SIDE_LIMIT);
      c2                = c1 + {16'd0, mask[SLOT_CRC_LO]};
      mask[SLOT_CRC_HI] = done && cfg.quick_disk_mode && (c2 < SIDE_LIMIT);
      c3                = c2 + {16'd0, mask[SLOT_CRC_HI]};
      mask[SLOT_END]    = side_end;

      bundle.mask       = mask;
      bundle.data_byte  = data;
      bundle.crc_raw    = crc_new;
      bundle.cnt_data   = c1;
      bundle.cnt_crc_lo = c2;
      bundle.cnt_crc_hi = c3;
      bundle_load       = accept && (mask != '0);

      // advance the side state
      phase_in = phase_ff;
      left_in  = left_ff;
      index_in = index_ff;
      btype_in = btype_ff;
      flen_in  = flen_ff;
      crc_in   = crc_ff;
      count_in = count_ff;
      if (in_block) begin
         if (btype_eff == TYPE_HEADER && index_eff == IDX_LEN_LO) begin
            flen_in = {flen_ff[15:8], data};
         end else if (btype_eff == TYPE_HEADER && index_eff == IDX_LEN_HI) begin
            flen_in = {data, flen_ff[7:0]};
         end
         index_in = (index_eff < IDX_MAX) ? index_eff + 5'd1 : index_eff;
         left_in  = left_dec;
         btype_in = btype_eff;
         crc_in   = crc_new;
         count_in = c3;
         phase_in = done ? PH_EXPECT : PH_BLOCK;
      end else if (phase_ff == PH_EXPECT && !skip) begin
         phase_in = PH_STOPPED;
      end
      if (side_end) begin
         phase_in = PH_EXPECT;
         left_in  = '0;
         index_in = '0;
         btype_in = '0;
         crc_in   = CRC_INIT;
         count_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_EXPECT;
         left_ff  <= '0;
         index_ff <= '0;
         btype_ff <= '0;
         flen_ff  <= '0;
         crc_ff   <= CRC_INIT;
         count_ff <= '0;
      end else if (accept) begin
         phase_ff <= phase_in;
         left_ff  <= left_in;
         index_ff <= index_in;
         btype_ff <= btype_in;
         flen_ff  <= flen_in;
         crc_ff   <= crc_in;
         count_ff <= count_in;
      end
   end

endmodule

// ===== src/dbx_serial.sv =====
// Result serialiser: bundle register feeding a one-word output register.
module dbx_serial
   import dbx_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  bundle_type         bundle,
   input  logic               bundle_load,
   output logic               can_load,
   output logic               out_valid,
   input  logic               out_ready,
   output logic [BYTE_W-1:0]  out_byte,
   output logic [KIND_W-1:0]  out_kind,
   output logic [COUNT_W-1:0] out_count,
   output logic               out_last
);

   bundle_type         hold_ff;
   logic [SLOTS-1:0]   mask_ff, mask_in, sel, rest;
   logic               valid_ff, valid_in, move;
   logic [BYTE_W-1:0]  byte_ff, byte_in;
   logic [KIND_W-1:0]  kind_ff, kind_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               last_ff, last_in;
   logic [15:0]        crc_fin;

   always_comb begin
      sel      = mask_ff & (~mask_ff + 4'd1);
      rest     = mask_ff & ~sel;
      move     = (mask_ff != '0) && (!valid_ff || out_ready);
      can_load = (mask_ff == '0) || (move && rest == '0);
      crc_fin  = crc_finish(hold_ff.crc_raw);

      byte_in  = byte_ff;
      kind_in  = kind_ff;
      count_in = count_ff;
      last_in  = last_ff;
      priority if (sel[SLOT_DATA]) begin
         byte_in  = hold_ff.data_byte;
         kind_in  = KIND_DATA;
         count_in = hold_ff.cnt_data;
      end else if (sel[SLOT_CRC_LO]) begin
         byte_in  = crc_fin[7:0];
         kind_in  = KIND_CRC;
         count_in = hold_ff.cnt_crc_lo;
      end else if (sel[SLOT_CRC_HI]) begin
         byte_in  = crc_fin[15:8];
         kind_in  = KIND_CRC;
         count_in = hold_ff.cnt_crc_hi;
      end else begin
         byte_in  = '0;
         kind_in  = KIND_END;
         count_in = hold_ff.cnt_crc_hi;
      end
      last_in = (rest == '0);

      valid_in = valid_ff;
      if (move) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end

      mask_in = mask_ff;
      if (bundle_load) begin
         mask_in = bundle.mask;
      end else if (move) begin
         mask_in = rest;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         mask_ff  <= mask_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (bundle_load) begin
         hold_ff <= bundle;
      end
      if (move) begin
         byte_ff  <= byte_in;
         kind_ff  <= kind_in;
         count_ff <= count_in;
         last_ff  <= last_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_byte  = byte_ff;
   assign out_kind  = kind_ff;
   assign out_count = count_ff;
   assign out_last  = last_ff;

endmodule

// ===== src/disk_block_extractor_crc16_unit.sv =====
// Disk block extractor with per-block CRC-16: configuration registers and top level.
// Path: an accepted word's results pass the bundle register, then the output register.
// Throughput: one word per cycle while the output is not stalled and each word yields
// at most one result; with more, the single output register holds the input back.
// Reset: synchronous; clears parser state, pending results and the configuration
// registers to their defaults.
module disk_block_extractor_crc16_unit
   import dbx_pkg::*;
#(
   parameter int unsigned MAX_SIDE_BYTES = 65536
) (
   input logic         clock,
   input logic         reset,
   dbx_req_if.sink     req_ch,
   dbx_rsp_if.source   rsp_ch,
   dbx_csr_if.sink     csr_ch
);

   localparam logic [COUNT_W-1:0] SIDE_LIMIT =
      (MAX_SIDE_BYTES > 131071) ? 17'd131071 : COUNT_W'(MAX_SIDE_BYTES);

   cfg_type    cfg_ff;
   bundle_type bundle;
   logic       bundle_load, can_load, accept, csr_write;

   assign csr_ch.ready = 1'b1;
   assign csr_write    = csr_ch.valid && csr_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.quick_disk_mode <= 1'b0;
         cfg_ff.gap_code        <= GAP_RESET;
         cfg_ff.mark_code       <= MARK_RESET;
         cfg_ff.crc_first_code  <= CRC_FIRST_RESET;
         cfg_ff.crc_second_code <= CRC_SECOND_RESET;
      end else if (csr_write) begin
         unique case (csr_ch.index)
            REG_QUICK_DISK: cfg_ff.quick_disk_mode <= csr_ch.data[0];
            REG_GAP:        cfg_ff.gap_code        <= csr_ch.data;
            REG_MARK:       cfg_ff.mark_code       <= csr_ch.data;
            REG_CRC_FIRST:  cfg_ff.crc_first_code  <= csr_ch.data;
            REG_CRC_SECOND: cfg_ff.crc_second_code <= csr_ch.data;
            default: ;
         endcase
      end
   end

   assign req_ch.ready = can_load;
   assign accept       = req_ch.valid && can_load;

   dbx_parse #(
      .SIDE_LIMIT(SIDE_LIMIT)
   ) u_parse (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .image_word (req_ch.image_word),
      .side_end   (req_ch.side_end),
      .cfg        (cfg_ff),
      .bundle     (bundle),
      .bundle_load(bundle_load)
   );

   dbx_serial u_serial (
      .clock      (clock),
      .reset      (reset),
      .bundle     (bundle),
      .bundle_load(bundle_load),
      .can_load   (can_load),
      .out_valid  (rsp_ch.valid),
      .out_ready  (rsp_ch.ready),
      .out_byte   (rsp_ch.out_byte),
      .out_kind   (rsp_ch.byte_kind),
      .out_count  (rsp_ch.bytes_emitted),
      .out_last   (rsp_ch.run_last)
   );

   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.byte_kind == KIND_END |-> rsp_ch.run_last)
      else $error("end word not marked last");

   a_end_byte_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.byte_kind == KIND_END |-> rsp_ch.out_byte == '0)
      else $error("end word carries a byte");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.byte_kind != KIND_END |->
         rsp_ch.bytes_emitted != '0 && rsp_ch.bytes_emitted <= SIDE_LIMIT)
      else $error("byte count out of range");

   a_no_accept_full: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.ready && !rsp_ch.run_last |-> !req_ch.ready)
      else $error("input taken while results of a word are pending");

endmodule
